FILE: rtl/ctint_pkg.sv
// Shared types, constants and register map of the clamped table interpolator.
`timescale 1ns / 1ps
package ctint_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int OUT_DEPTH = 8;

    localparam int TEMP_W = 24;
    localparam int IDX_W  = 10;
    localparam int WORD_W = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_T_MIN      = 3'd0;
    localparam logic [2:0] REG_T_MAX      = 3'd1;
    localparam logic [2:0] REG_STEP       = 3'd2;
    localparam logic [2:0] REG_INV_STEP   = 3'd3;
    localparam logic [2:0] REG_INDEX_LOW  = 3'd4;
    localparam logic [2:0] REG_INDEX_HIGH = 3'd5;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_EVAL = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0] t_min;
        logic [TEMP_W-1:0] t_max;
        logic [TEMP_W-1:0] inv_step;
        logic [IDX_W-1:0]  index_low;
        logic [IDX_W-1:0]  index_high;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     below_range;
        logic                     above_range;
    } res_t;

endpackage

FILE: rtl/clamped_table_interpolator_core.sv
// Evaluate results pass pipeline stages s1 to s5, then the result queue, to the output.
// Throughput: one item (load or evaluate) per cycle while in_ready is high; the table
// sits in two mirrored RAM copies so both neighbor entries are read in the same cycle.
// Input stalls only when 8 results are in flight or queued (output credit counter).
// Reset clears registers and pipeline control; table contents are undefined until loaded.
`timescale 1ns / 1ps
module clamped_table_interpolator_core #(
    parameter int TABLE_DEPTH = ctint_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctint_pkg::PADDR_W-1:0]       paddr,
    input  logic [ctint_pkg::PDATA_W-1:0]       pwdata,
    output logic [ctint_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [ctint_pkg::IDX_W-1:0]         table_addr,
    input  logic signed [ctint_pkg::WORD_W-1:0] table_word,
    input  logic [ctint_pkg::TEMP_W-1:0]        temperature,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ctint_pkg::WORD_W-1:0] value,
    output logic                                below_range,
    output logic                                above_range
);
    import ctint_pkg::*;

    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    cfg_t              cfg;
    res_t              eval_res, head;
    logic              eval_valid;
    logic              in_fire, pop;
    logic [PEND_W-1:0] pending_reg, pending_next;

    ctint_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctint_eval #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .action      (action),
        .table_addr  (table_addr),
        .table_word  (table_word),
        .temperature (temperature),
        .cfg         (cfg),
        .res_valid   (eval_valid),
        .res         (eval_res)
    );

    ctint_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (eval_valid),
        .push_data  (eval_res),
        .pop        (pop),
        .head_valid (out_valid),
        .head_data  (head)
    );

    // credits: every accepted evaluate item holds a queue slot until it is taken
    assign in_ready = (pending_reg < PEND_W'(OUT_DEPTH));
    assign in_fire  = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && (action == ACT_EVAL) && !pop)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (pop && !(in_fire && (action == ACT_EVAL)))
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    assign value       = head.value;
    assign below_range = head.below_range;
    assign above_range = head.above_range;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(OUT_DEPTH))
        else $error("pending item count exceeds queue depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(below_range && above_range))
        else $error("item flagged both below and above range");

    a_load_no_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (action == ACT_LOAD) && !pop) |=> (pending_reg == $past(pending_reg)))
        else $error("load item took an output credit");

    a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid |-> (pending_reg != '0))
        else $error("result produced without a reserved slot");

endmodule

FILE: rtl/ctint_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ctint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ctint_cfg.sv
// APB register file holding bounds, reciprocal step and clamp indexes.
`timescale 1ns / 1ps
module ctint_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ctint_pkg::PADDR_W-1:0]   paddr,
    input  logic [ctint_pkg::PDATA_W-1:0]   pwdata,
    output logic [ctint_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    output ctint_pkg::cfg_t                 cfg
);
    import ctint_pkg::*;

    logic [TEMP_W-1:0] t_min_reg;
    logic [TEMP_W-1:0] t_max_reg;
    logic [TEMP_W-1:0] step_reg;
    logic [TEMP_W-1:0] inv_step_reg;
    logic [IDX_W-1:0]  index_low_reg;
    logic [IDX_W-1:0]  index_high_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_min_reg      <= '0;
            t_max_reg      <= '1;
            step_reg       <= TEMP_W'(65536);
            inv_step_reg   <= TEMP_W'(65536);
            index_low_reg  <= '0;
            index_high_reg <= '1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_T_MIN:      t_min_reg      <= pwdata[TEMP_W-1:0];
                REG_T_MAX:      t_max_reg      <= pwdata[TEMP_W-1:0];
                REG_STEP:       step_reg       <= pwdata[TEMP_W-1:0];
                REG_INV_STEP:   inv_step_reg   <= pwdata[TEMP_W-1:0];
                REG_INDEX_LOW:  index_low_reg  <= pwdata[IDX_W-1:0];
                REG_INDEX_HIGH: index_high_reg <= pwdata[IDX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_T_MIN:      prdata = PDATA_W'(t_min_reg);
            REG_T_MAX:      prdata = PDATA_W'(t_max_reg);
            REG_STEP:       prdata = PDATA_W'(step_reg);
            REG_INV_STEP:   prdata = PDATA_W'(inv_step_reg);
            REG_INDEX_LOW:  prdata = PDATA_W'(index_low_reg);
            REG_INDEX_HIGH: prdata = PDATA_W'(index_high_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.t_min      = t_min_reg;
    assign cfg.t_max      = t_max_reg;
    assign cfg.inv_step   = inv_step_reg;
    assign cfg.index_low  = index_low_reg;
    assign cfg.index_high = index_high_reg;

endmodule

FILE: rtl/ctint_eval.sv
// Free-running load/eval pipeline over two mirrored copies of the property table.
`timescale 1ns / 1ps
module ctint_eval #(
    parameter int TABLE_DEPTH = ctint_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic                              action,
    input  logic [ctint_pkg::IDX_W-1:0]       table_addr,
    input  logic signed [ctint_pkg::WORD_W-1:0] table_word,
    input  logic [ctint_pkg::TEMP_W-1:0]      temperature,
    input  ctint_pkg::cfg_t                   cfg,
    output logic                              res_valid,
    output ctint_pkg::res_t                   res
);
    import ctint_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [16:0] SEG_LIM  = 17'(TABLE_DEPTH - 2);
    localparam logic [16:0] LAST_IDX = 17'(TABLE_DEPTH - 1);
    localparam logic [16:0] DEPTH17  = 17'(TABLE_DEPTH);
    localparam logic [16:0] FRAC_ONE = 17'd65536;

    // stage 1: range test and offset
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_eval_reg;
    logic [IDX_W-1:0]    s1_addr_reg;
    logic [WORD_W-1:0]   s1_word_reg;
    logic                s1_below_reg, s1_above_reg;
    logic [TEMP_W-1:0]   s1_d_reg;

    // stage 2: product, table write / read issue
    logic                s2_valid_reg;
    logic                s2_eval_reg;
    logic [IDX_W-1:0]    s2_addr_reg;
    logic [WORD_W-1:0]   s2_word_reg;
    logic                s2_below_reg, s2_above_reg;
    logic [2*TEMP_W-1:0] s2_p_reg;

    // stage 3: table data
    logic                s3_valid_reg;
    logic                s3_below_reg, s3_above_reg;
    logic [16:0]         s3_f_reg;

    // stage 4: difference
    logic                s4_valid_reg;
    logic                s4_below_reg, s4_above_reg;
    logic [16:0]         s4_f_reg;
    logic signed [32:0]  s4_diff_reg;
    logic signed [31:0]  s4_e0_reg;

    // stage 5: scaled difference
    logic                s5_valid_reg;
    logic                s5_below_reg, s5_above_reg;
    logic signed [50:0]  s5_prod_reg;
    logic signed [31:0]  s5_e0_reg;

    logic                below, above;
    logic [16:0]         seg, seg_c, frac, idx_lo, idx_hi, rd_a, rd_b, addr17;
    logic                flagged;
    logic                ram_we, ram_re;
    logic [WORD_W-1:0]   e0_raw, e1_raw;
    logic signed [34:0]  step_part;
    logic signed [35:0]  sum;

    assign below = temperature < cfg.t_min;
    assign above = !below && (temperature > cfg.t_max);
    assign s1_valid_next = in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_eval_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_eval_reg  <= (action == ACT_EVAL);
        s1_addr_reg  <= table_addr;
        s1_word_reg  <= table_word;
        s1_below_reg <= below;
        s1_above_reg <= above;
        s1_d_reg     <= temperature - cfg.t_min;

        s2_eval_reg  <= s1_eval_reg;
        s2_addr_reg  <= s1_addr_reg;
        s2_word_reg  <= s1_word_reg;
        s2_below_reg <= s1_below_reg;
        s2_above_reg <= s1_above_reg;
        s2_p_reg     <= s1_d_reg * cfg.inv_step;

        s3_below_reg <= s2_below_reg;
        s3_above_reg <= s2_above_reg;
        s3_f_reg     <= flagged ? 17'd0 : frac;

        s4_below_reg <= s3_below_reg;
        s4_above_reg <= s3_above_reg;
        s4_f_reg     <= s3_f_reg;
        // a clamped result is the single entry; the neighbor read is discarded
        s4_diff_reg  <= (s3_below_reg || s3_above_reg) ? 33'sd0
                        : 33'(signed'(e1_raw)) - 33'(signed'(e0_raw));
        s4_e0_reg    <= signed'(e0_raw);

        s5_below_reg <= s4_below_reg;
        s5_above_reg <= s4_above_reg;
        s5_prod_reg  <= 51'(s4_diff_reg) * 51'(signed'({1'b0, s4_f_reg}));
        s5_e0_reg    <= s4_e0_reg;
    end

    // segment clamp keeps seg+1 inside the table; fraction then reads as 1.0
    always_comb
    begin
        seg = {1'b0, s2_p_reg[47:32]};
        if (seg > SEG_LIM)
        begin
            seg_c = SEG_LIM;
            frac  = FRAC_ONE;
        end
        else
        begin
            seg_c = seg;
            frac  = {1'b0, s2_p_reg[31:16]};
        end
        idx_lo  = {7'd0, cfg.index_low};
        idx_hi  = {7'd0, cfg.index_high};
        if (idx_lo >= DEPTH17)
        begin
            idx_lo = LAST_IDX;
        end
        if (idx_hi >= DEPTH17)
        begin
            idx_hi = LAST_IDX;
        end
        flagged = s2_below_reg || s2_above_reg;
        if (s2_below_reg)
        begin
            rd_a = idx_lo;
        end
        else if (s2_above_reg)
        begin
            rd_a = idx_hi;
        end
        else
        begin
            rd_a = seg_c;
        end
        rd_b   = seg_c + 17'd1;
        addr17 = {7'd0, s2_addr_reg};
    end

    assign ram_we = s2_valid_reg && !s2_eval_reg && (addr17 < DEPTH17);
    assign ram_re = s2_valid_reg && s2_eval_reg;

    // both copies take every load so each read port sees the whole table
    ctint_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr17[AW-1:0]),
        .wdata (s2_word_reg),
        .re    (ram_re),
        .raddr (rd_a[AW-1:0]),
        .rdata (e0_raw)
    );

    ctint_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr17[AW-1:0]),
        .wdata (s2_word_reg),
        .re    (ram_re),
        .raddr (rd_b[AW-1:0]),
        .rdata (e1_raw)
    );

    // arithmetic shift of the product is the floor division by 2^16
    assign step_part = s5_prod_reg[50:16];
    assign sum       = 36'(s5_e0_reg) + 36'(step_part);

    always_comb
    begin
        res.below_range = s5_below_reg;
        res.above_range = s5_above_reg;
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111)
        begin
            res.value = sum[31:0];
        end
        else if (sum[35])
        begin
            res.value = 32'sh8000_0000;
        end
        else
        begin
            res.value = 32'sh7fff_ffff;
        end
    end

    assign res_valid = s5_valid_reg;

endmodule

FILE: rtl/ctint_fifo.sv
// Result queue that decouples the pipeline from output backpressure.
`timescale 1ns / 1ps
module ctint_fifo #(
    parameter int DEPTH = ctint_pkg::OUT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctint_pkg::res_t   push_data,
    input  logic              pop,
    output logic              head_valid,
    output ctint_pkg::res_t   head_data
);
    import ctint_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

endmodule

FILE: tb/clamped_table_interpolator_core_tb.sv
// Self-checking testbench for the clamped table interpolator core.
`timescale 1ns / 1ps
module clamped_table_interpolator_core_tb;
    import ctint_pkg::*;

    localparam int TDEPTH = TABLE_DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = 12;      // covers pipeline stages s1 to s5 plus a margin
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic [TEMP_W-1:0] TEMP_TOP = 24'hFF_FFFF;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     action = ACT_LOAD;
    logic [IDX_W-1:0]         table_addr = '0;
    logic signed [WORD_W-1:0] table_word = '0;
    logic [TEMP_W-1:0]        temperature = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] value;
    logic                     below_range;
    logic                     above_range;

    // Shadow of the block: table contents and register values
    logic signed [WORD_W-1:0] prop_table [TDEPTH];
    logic [TEMP_W-1:0]        lo_bound = '0;
    logic [TEMP_W-1:0]        hi_bound = TEMP_TOP;
    logic [TEMP_W-1:0]        step_reg = 24'd65536;
    logic [TEMP_W-1:0]        seg_scale = 24'd65536;
    logic [IDX_W-1:0]         idx_below = '0;
    logic [IDX_W-1:0]         idx_above = 10'd1023;

    res_t expected_results[$];
    int   errors = 0;
    int   stall_count = 0;
    int   hold_left = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;

    clamped_table_interpolator_core #(.TABLE_DEPTH(TDEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .table_addr(table_addr),
        .table_word(table_word),
        .temperature(temperature),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value(value),
        .below_range(below_range),
        .above_range(above_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint table_at(input int idx);
        if (idx >= TDEPTH)
            idx = TDEPTH - 1;
        return longint'(prop_table[idx]);
    endfunction

    function automatic res_t interpolate(input logic [TEMP_W-1:0] t);
        res_t        r;
        logic [47:0] prod;
        int          seg;
        longint      frac;
        longint      e0;
        longint      e1;
        longint      acc;
        r.below_range = 1'b0;
        r.above_range = 1'b0;
        if (t < lo_bound)
        begin
            r.below_range = 1'b1;
            acc = table_at(idx_below);
        end
        else if (t > hi_bound)
        begin
            r.above_range = 1'b1;
            acc = table_at(idx_above);
        end
        else
        begin
            prod = ({24'd0, t} - {24'd0, lo_bound}) * {24'd0, seg_scale};
            seg = int'(prod[47:32]);
            frac = longint'(prod[31:16]);
            // past the last segment: pin to the final entry
            if (seg > TDEPTH - 2)
            begin
                seg = TDEPTH - 2;
                frac = 65536;
            end
            e0 = table_at(seg);
            e1 = table_at(seg + 1);
            acc = e0 + (((e1 - e0) * frac) >>> 16);
        end
        if (acc > longint'(WORD_MAX))
            acc = longint'(WORD_MAX);
        if (acc < longint'(WORD_MIN))
            acc = longint'(WORD_MIN);
        r.value = acc[WORD_W-1:0];
        return r;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%t: %s", $realtime, msg);
    endtask

    // Sender: called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic act, input logic [IDX_W-1:0] addr,
                             input logic signed [WORD_W-1:0] word,
                             input logic [TEMP_W-1:0] temp);
        int gap;
        if (tx_idle_on && $urandom_range(0, 99) < 7)
        begin
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action = act;
        table_addr = addr;
        table_word = word;
        temperature = temp;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (act == ACT_LOAD)
        begin
            if (addr < TDEPTH)
                prop_table[addr] = word;
        end
        else
            expected_results.push_back(interpolate(temp));
        @(negedge clk);
    endtask

    task automatic load_entry(input int addr, input logic signed [WORD_W-1:0] word);
        send_item(ACT_LOAD, IDX_W'(addr), word, TEMP_W'($urandom));
    endtask

    task automatic eval_temp(input logic [TEMP_W-1:0] temp);
        send_item(ACT_EVAL, IDX_W'($urandom), WORD_W'($urandom), temp);
    endtask

    // Sender stops and waits until every result is back and the pipe is empty
    task automatic settle();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] kept;
        case (idx)
            REG_T_MIN:
            begin
                lo_bound = data[TEMP_W-1:0];
                kept = PDATA_W'(data[TEMP_W-1:0]);
            end
            REG_T_MAX:
            begin
                hi_bound = data[TEMP_W-1:0];
                kept = PDATA_W'(data[TEMP_W-1:0]);
            end
            REG_STEP:
            begin
                step_reg = data[TEMP_W-1:0];
                kept = PDATA_W'(data[TEMP_W-1:0]);
            end
            REG_INV_STEP:
            begin
                seg_scale = data[TEMP_W-1:0];
                kept = PDATA_W'(data[TEMP_W-1:0]);
            end
            REG_INDEX_LOW:
            begin
                idx_below = data[IDX_W-1:0];
                kept = PDATA_W'(data[IDX_W-1:0]);
            end
            REG_INDEX_HIGH:
            begin
                idx_above = data[IDX_W-1:0];
                kept = PDATA_W'(data[IDX_W-1:0]);
            end
            default: kept = '0;
        endcase
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        // read it back
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== kept)
            note_error($sformatf("readback reg %0d: got %h expected %h", idx, prdata, kept));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_config(input logic [TEMP_W-1:0] tmin, input logic [TEMP_W-1:0] tmax,
                              input logic [TEMP_W-1:0] stp, input logic [TEMP_W-1:0] inv,
                              input logic [IDX_W-1:0] ilo, input logic [IDX_W-1:0] ihi);
        settle();
        reg_write(REG_T_MIN, PDATA_W'(tmin));
        reg_write(REG_T_MAX, PDATA_W'(tmax));
        reg_write(REG_STEP, PDATA_W'(stp));
        reg_write(REG_INV_STEP, PDATA_W'(inv));
        reg_write(REG_INDEX_LOW, PDATA_W'(ilo));
        reg_write(REG_INDEX_HIGH, PDATA_W'(ihi));
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [TEMP_W-1:0] rand_temp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60 && lo_bound <= hi_bound)
            return TEMP_W'($urandom_range(lo_bound, hi_bound));
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0: return lo_bound;
                1: return hi_bound;
                2: return lo_bound - 1'b1;
                default: return hi_bound + 1'b1;
            endcase
        end
        return TEMP_W'($urandom);
    endfunction

    // Every entry gets written first, so no evaluate ever reads an unwritten word
    task automatic test_table_fill();
        for (int a = 0; a < TDEPTH; a++)
        begin
            if (a < 4 || a >= TDEPTH - 4)
                load_entry(a, (a % 2) ? WORD_MIN : WORD_MAX);
            else
                load_entry(a, rand_word());
        end
    endtask

    task automatic test_reset_values();
        eval_temp('0);
        eval_temp(24'h00_8000);     // halfway between entries 0 and 1 (WORD_MAX and WORD_MIN)
        eval_temp(24'h00_0001);
        eval_temp(TEMP_TOP);
    endtask

    task automatic test_range_bounds();
        set_config(24'h10_0000, 24'h20_0000, 24'h00_4000, 24'h04_0000, 10'd0, 10'd1023);
        eval_temp(24'h0F_FFFF);
        eval_temp(24'h10_0000);
        eval_temp(24'h20_0000);
        eval_temp(24'h20_0001);
        set_config(24'h10_0000, 24'h20_0000, 24'h00_4000, 24'h04_0000, 10'd1023, 10'd0);
        eval_temp('0);
        eval_temp(TEMP_TOP);
    endtask

    task automatic test_segment_clamp();
        set_config('0, TEMP_TOP, 24'h00_4000, 24'h04_0000, 10'd0, 10'd1023);
        eval_temp(24'hFF_8000);     // exactly on the second-to-last entry
        eval_temp(24'hFF_8001);
        eval_temp(24'hFF_C000);     // one past: pinned to the last entry
        eval_temp(TEMP_TOP);
        set_config('0, TEMP_TOP, 24'h00_0001, TEMP_TOP, 10'd0, 10'd1023);
        eval_temp(24'h00_0001);
        eval_temp(24'h00_0200);
        eval_temp(24'h01_0000);
    endtask

    task automatic test_inverted_bounds();
        set_config(24'h80_0000, 24'h40_0000, 24'h01_0000, 24'h01_0000, 10'd2, 10'd1021);
        eval_temp(24'h10_0000);
        eval_temp(24'h60_0000);
        eval_temp(24'h80_0000);
        eval_temp(24'h90_0000);
    endtask

    task automatic test_zero_scale();
        set_config('0, TEMP_TOP, TEMP_TOP, '0, 10'd0, 10'd1023);
        eval_temp(24'h12_3456);
        eval_temp(TEMP_TOP);
    endtask

    // Load followed by an evaluate that reads the new word, at most a random idle gap between
    task automatic test_load_then_read();
        set_config('0, TEMP_TOP, 24'h01_0000, 24'h01_0000, 10'd0, 10'd1023);
        load_entry(5, WORD_MAX);
        eval_temp(24'h05_8000);
        load_entry(6, WORD_MIN);
        eval_temp(24'h05_C000);
    endtask

    task automatic test_output_stall();
        settle();
        hold_left <= HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            eval_temp(rand_temp());
        settle();
    endtask

    task automatic random_config(input int phase);
        logic [TEMP_W-1:0] tmin;
        logic [TEMP_W-1:0] tmax;
        logic [TEMP_W-1:0] tmp;
        logic [TEMP_W-1:0] inv;
        logic [IDX_W-1:0]  ilo;
        logic [IDX_W-1:0]  ihi;
        longint unsigned   span;
        longint unsigned   fit;
        tmin = TEMP_W'($urandom);
        tmax = TEMP_W'($urandom);
        if (phase == 0)
        begin
            tmin = '0;
            tmax = TEMP_TOP;
        end
        else if ((phase == 5) != (tmin > tmax))
        begin
            tmp = tmin;
            tmin = tmax;
            tmax = tmp;
        end
        span = (tmin <= tmax) ? longint'(tmax - tmin) + 1 : 64'd1;
        // scale so the range maps roughly onto the table, sometimes running past its end
        fit = (64'd1023 << 32) / span;
        if ($urandom_range(0, 3) == 0)
            fit = fit + fit / 4;
        inv = (fit > TEMP_TOP) ? TEMP_TOP : ((fit == 0) ? 24'd1 : TEMP_W'(fit));
        if (phase == 2)
            inv = TEMP_W'($urandom_range(1, TEMP_TOP));
        ilo = ($urandom_range(0, 3) == 0) ? 10'd1023 : IDX_W'($urandom);
        ihi = ($urandom_range(0, 3) == 0) ? 10'd0 : IDX_W'($urandom);
        set_config(tmin, tmax, TEMP_W'($urandom_range(1, TEMP_TOP)), inv, ilo, ihi);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            random_config(phase);
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(0, 99) < 20)
                    load_entry($urandom_range(0, TDEPTH - 1), rand_word());
                else
                    eval_temp(rand_temp());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready = !(rx_idle_on && $urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                note_error($sformatf("unexpected result value=%h below=%b above=%b",
                                     value, below_range, above_range));
            else
            begin
                want = expected_results.pop_front();
                if (value !== want.value || below_range !== want.below_range
                    || above_range !== want.above_range)
                    note_error($sformatf("result %h/%b/%b expected %h/%b/%b",
                                         value, below_range, above_range,
                                         want.value, want.below_range, want.above_range));
            end
        end
    end

    // Watchdog on cycles with no accepted item and no register access
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_count = 0;
        else
        begin
            stall_count = stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_table_fill();
        test_reset_values();
        test_range_bounds();
        test_segment_clamp();
        test_inverted_bounds();
        test_zero_scale();
        test_load_then_read();
        test_output_stall();
        test_random_traffic();
        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
